[hw/rtl/mkd_pkg.sv]
// shared widths, register codes and controller/datapath types for the key scanner
package mkd_pkg;

  // defaults for the top-level parameters
  localparam int NUM_KEYS_DEF   = 32;
  localparam int FIFO_DEPTH_DEF = 16;

  // keys that auto-repeat while held
  localparam int UP_KEY_CODE   = 1;
  localparam int DOWN_KEY_CODE = 2;

  // fixed field widths
  localparam int LEVEL_W    = 32;
  localparam int CNT_W      = 16;
  localparam int CODE_W     = 8;
  localparam int KCNT_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASE_MODE       = 3'd0,
    CFG_KEY_COUNT          = 3'd1,
    CFG_RELEASE_LONG_THRE  = 3'd2,
    CFG_RELEASE_EXTRA_THRE = 3'd3,
    CFG_PRESS_LONG_THRE    = 3'd4,
    CFG_HOLD_COUNT_MAX     = 3'd5,
    CFG_LONG_OFFSET        = 3'd6,
    CFG_EXTRA_LONG_OFFSET  = 3'd7
  } cfg_idx_t;

  // configuration register file
  typedef struct packed {
    logic              release_mode;
    logic [KCNT_W-1:0] key_count;
    logic [CNT_W-1:0]  release_long_thre;
    logic [CNT_W-1:0]  release_extra_thre;
    logic [CNT_W-1:0]  press_long_thre;
    logic [CNT_W-1:0]  hold_count_max;
    logic [CODE_W-1:0] long_offset;
    logic [CODE_W-1:0] extra_long_offset;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic scan_start;
    logic pop_start;
    logic key_step;
    logic edge_step;
    logic adv_key;
    logic pop_read;
    logic load_result;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic defer;
    logic brk;
    logic last;
    logic full;
    logic empty;
    logic lim_zero;
  } dp_sts_t;

endpackage

[hw/rtl/mkd_req_if.sv]
// request channel: scan tick or pop
interface mkd_req_if;
  import mkd_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [LEVEL_W-1:0] key_levels;

  modport source (output valid, output req_type, output key_levels, input ready);
  modport sink   (input valid, input req_type, input key_levels, output ready);
endinterface

[hw/rtl/mkd_rsp_if.sv]
// response channel: one word per request
interface mkd_rsp_if;
  import mkd_pkg::*;

  logic              valid;
  logic              ready;
  logic              code_added;
  logic [CODE_W-1:0] popped_code;
  logic              fifo_empty;

  modport source (output valid, output code_added, output popped_code, output fifo_empty,
                  input ready);
  modport sink   (input valid, input code_added, input popped_code, input fifo_empty,
                  output ready);
endinterface

[hw/rtl/mkd_cfg_if.sv]
// configuration write channel
interface mkd_cfg_if;
  import mkd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mkd_ram.sv]
// generic single-write, single-read ram with registered read data
module mkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/mkd_ctrl.sv]
// sequencer for scan walks, pops and the response register
module mkd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_type,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  mkd_pkg::dp_sts_t  sts,
  output mkd_pkg::dp_cmd_t  cmd
);
  import mkd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EDGE,
    ST_POP,
    ST_FINISH
  } state_t;

  state_t state;
  logic   start;
  logic   rsp_free;

  assign start    = (state == ST_IDLE) && req_valid && req_ready;
  assign rsp_free = !rsp_valid || rsp_ready;

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.scan_start  = start && !req_type;
    cmd.pop_start   = start && req_type;
    cmd.key_step    = (state == ST_SCAN);
    cmd.edge_step   = (state == ST_EDGE);
    cmd.adv_key     = ((state == ST_SCAN) && !sts.defer) || (state == ST_EDGE);
    cmd.pop_read    = (state == ST_POP);
    cmd.load_result = (state == ST_FINISH) && rsp_free;
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      // a taken word clears valid unless the next word is loaded in this cycle
      if (rsp_valid && rsp_ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            req_ready <= 1'b0;
            if (req_type) begin
              state <= ST_POP;
            end else if (sts.lim_zero) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (sts.defer) begin
            state <= ST_EDGE;
          end else if (sts.brk || sts.last) begin
            state <= ST_FINISH;
          end
        end
        ST_EDGE: begin
          if (sts.full || sts.last) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_POP: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            req_ready <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/mkd_dp.sv]
// debounce, hold counters, code fifo and response registers
module mkd_dp #(
  parameter int NUM_KEYS   = mkd_pkg::NUM_KEYS_DEF,
  parameter int FIFO_DEPTH = mkd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mkd_pkg::cfg_t                 cfg_regs,
  input  mkd_pkg::dp_cmd_t              cmd,
  output mkd_pkg::dp_sts_t              sts,
  input  logic [mkd_pkg::LEVEL_W-1:0]   key_levels,
  output logic                          res_code_added,
  output logic [mkd_pkg::CODE_W-1:0]    res_popped_code,
  output logic                          res_fifo_empty
);
  import mkd_pkg::*;

  localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [KCNT_W-1:0] KEY_MAX  = KCNT_W'(NUM_KEYS);

  logic [LEVEL_W-1:0]   prev_sample;
  logic [LEVEL_W-1:0]   stable_levels;
  logic [LEVEL_W-1:0]   edges;
  logic [CNT_W-1:0]     hold [NUM_KEYS];
  logic [KEY_IDX_W-1:0] key_idx;
  logic [KCNT_W-1:0]    key_lim;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wr_ptr;
  logic                 added;
  logic                 pop_hit;
  logic [CODE_W-1:0]    edge_code;

  logic [LEVEL_W-1:0]   st_new;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CNT_W-1:0]     cnt1;
  logic [CNT_W-1:0]     cnt_fin;
  logic                 st_bit;
  logic                 edge_bit;
  logic                 rel;
  logic                 is_rep;
  logic                 push1;
  logic                 push1_ok;
  logic [CODE_W-1:0]    kc;
  logic [CODE_W-1:0]    code1;
  logic [CODE_W-1:0]    code2;
  logic [CODE_W-1:0]    add_long;
  logic [CODE_W-1:0]    add_extra;
  logic [PTR_W-1:0]     wr_next;
  logic [PTR_W-1:0]     rd_next;
  logic                 full;
  logic                 empty;
  logic                 wr_en;
  logic [CODE_W-1:0]    wr_data;
  logic                 rd_en;
  logic [CODE_W-1:0]    rd_data;

  // two-sample debounce
  assign st_new = (stable_levels | (key_levels & prev_sample)) & (key_levels | prev_sample);
  assign rel    = cfg_regs.release_mode;

  // fifo pointers
  assign wr_next = (wr_ptr == LAST_PTR) ? '0 : PTR_W'(wr_ptr + 1'b1);
  assign rd_next = (rd_ptr == LAST_PTR) ? '0 : PTR_W'(rd_ptr + 1'b1);
  assign full    = (wr_next == rd_ptr);
  assign empty   = (rd_ptr == wr_ptr);

  // current key
  assign cnt      = hold[key_idx];
  assign cnt_inc  = CNT_W'(cnt + 1'b1);
  assign st_bit   = stable_levels[key_idx];
  assign edge_bit = edges[key_idx];
  assign kc       = CODE_W'(key_idx) + CODE_W'(1);
  assign is_rep   = (kc == CODE_W'(UP_KEY_CODE)) || (kc == CODE_W'(DOWN_KEY_CODE));

  // hold count update and the long or repeat code
  always_comb begin
    cnt1  = cnt;
    push1 = 1'b0;
    code1 = kc + cfg_regs.long_offset;
    if (st_bit) begin
      if (cnt < cfg_regs.hold_count_max) begin
        cnt1  = cnt_inc;
        push1 = (cnt_inc == cfg_regs.press_long_thre) && !rel;
      end else if (is_rep) begin
        cnt1  = cfg_regs.press_long_thre;
        push1 = 1'b1;
        code1 = kc;
      end
    end else if (!rel) begin
      cnt1 = '0;
    end
  end

  // edge code, with hold-time offsets on release
  assign add_long  = (cnt1 >= cfg_regs.release_long_thre)  ? cfg_regs.long_offset : '0;
  assign add_extra = (cnt1 >= cfg_regs.release_extra_thre) ? cfg_regs.extra_long_offset : '0;
  assign code2     = rel ? (kc + add_long + add_extra) : kc;
  assign cnt_fin   = (edge_bit && rel) ? '0 : cnt1;

  // fifo write: one code a cycle; a second code of the same key is held and written in the edge step
  assign push1_ok = push1 && !full;
  assign wr_en    = (cmd.key_step && (push1_ok || (edge_bit && !full)))
                 || (cmd.edge_step && !full);
  assign wr_data  = cmd.edge_step ? edge_code : (push1_ok ? code1 : code2);
  assign rd_en    = cmd.pop_read && !empty;

  // status
  always_comb begin
    sts          = '0;
    sts.defer    = push1_ok && edge_bit;
    sts.brk      = edge_bit && full;
    sts.last     = (KCNT_W'(key_idx) + KCNT_W'(1)) == key_lim;
    sts.full     = full;
    sts.empty    = empty;
    sts.lim_zero = (cfg_regs.key_count == '0);
  end

  // key state, pointers and walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample   <= '0;
      stable_levels <= '0;
      edges         <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold[k] <= '0;
      end
      key_idx <= '0;
      key_lim <= '0;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      added   <= 1'b0;
      pop_hit <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        prev_sample   <= key_levels;
        stable_levels <= st_new;
        edges         <= (st_new ^ stable_levels) & (rel ? stable_levels : st_new);
        key_idx       <= '0;
        key_lim       <= (cfg_regs.key_count > KEY_MAX) ? KEY_MAX : cfg_regs.key_count;
        added         <= 1'b0;
        pop_hit       <= 1'b0;
      end
      if (cmd.pop_start) begin
        added   <= 1'b0;
        pop_hit <= 1'b0;
      end
      if (cmd.key_step) begin
        hold[key_idx] <= cnt_fin;
      end
      if (cmd.adv_key) begin
        key_idx <= KEY_IDX_W'(key_idx + 1'b1);
      end
      if (wr_en) begin
        wr_ptr <= wr_next;
        added  <= 1'b1;
      end
      if (rd_en) begin
        rd_ptr  <= rd_next;
        pop_hit <= 1'b1;
      end
    end
  end

  // second code of a key, pushed in the following cycle if the fifo has room
  always_ff @(posedge clk) begin
    if (cmd.key_step && push1_ok && edge_bit) begin
      edge_code <= code2;
    end
  end

  // response word
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_code_added  <= added;
      res_popped_code <= pop_hit ? rd_data : '0;
      res_fifo_empty  <= empty;
    end
  end

  mkd_ram #(
    .WIDTH (CODE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

endmodule

[hw/rtl/multi_key_debounce_long_press_fifo.sv]
// top level: debounced key scanner with long-press codes and a code fifo
//
// Each request word is a scan tick (req_type 0, 32 raw key levels) or a pop (req_type 1).
// A scan debounces all 32 levels on acceptance, then walks the examined keys one per cycle
// through a single hold-counter update path, writing queued codes into the fifo store, which
// has one write port; a key that queues both a long/repeat code and an edge code holds the
// walk for an extra edge step that writes the second code. The walk ends early when an edge
// code finds the fifo full. A pop reads the store in ST_POP and answers in ST_FINISH: the
// store read is registered. The fifo holds FIFO_DEPTH-1 codes; a pop on an empty fifo
// returns 0. A new request is taken while the previous response still waits to be read.
// Configuration writes are taken at any time but belong between requests.
module multi_key_debounce_long_press_fifo #(
  parameter int NUM_KEYS   = mkd_pkg::NUM_KEYS_DEF,
  parameter int FIFO_DEPTH = mkd_pkg::FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mkd_req_if.sink   req,
  mkd_rsp_if.source rsp,
  mkd_cfg_if.sink   cfg
);
  import mkd_pkg::*;

  cfg_t    cfg_regs;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.release_mode       <= 1'b0;
      cfg_regs.key_count          <= KCNT_W'(32);
      cfg_regs.release_long_thre  <= CNT_W'(100);
      cfg_regs.release_extra_thre <= CNT_W'(300);
      cfg_regs.press_long_thre    <= CNT_W'(100);
      cfg_regs.hold_count_max     <= CNT_W'(150);
      cfg_regs.long_offset        <= CODE_W'(64);
      cfg_regs.extra_long_offset  <= CODE_W'(128);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_RELEASE_MODE:       cfg_regs.release_mode       <= cfg.data[0];
        CFG_KEY_COUNT:          cfg_regs.key_count          <= cfg.data[KCNT_W-1:0];
        CFG_RELEASE_LONG_THRE:  cfg_regs.release_long_thre  <= cfg.data[CNT_W-1:0];
        CFG_RELEASE_EXTRA_THRE: cfg_regs.release_extra_thre <= cfg.data[CNT_W-1:0];
        CFG_PRESS_LONG_THRE:    cfg_regs.press_long_thre    <= cfg.data[CNT_W-1:0];
        CFG_HOLD_COUNT_MAX:     cfg_regs.hold_count_max     <= cfg.data[CNT_W-1:0];
        CFG_LONG_OFFSET:        cfg_regs.long_offset        <= cfg.data[CODE_W-1:0];
        CFG_EXTRA_LONG_OFFSET:  cfg_regs.extra_long_offset  <= cfg.data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mkd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mkd_dp #(
    .NUM_KEYS   (NUM_KEYS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_regs        (cfg_regs),
    .cmd             (cmd),
    .sts             (sts),
    .key_levels      (req.key_levels),
    .res_code_added  (rsp.code_added),
    .res_popped_code (rsp.popped_code),
    .res_fifo_empty  (rsp.fifo_empty)
  );

  // fifo can never look full and empty at once
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(sts.full && sts.empty))
    else $error("fifo reports full and empty together");

  // a scan that queued a code leaves the fifo non-empty
  a_added_nonempty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.code_added |-> !rsp.fifo_empty)
    else $error("code queued but fifo reported empty");

  // a new response appears together with readiness for the next request
  a_rsp_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> req.ready)
    else $error("response issued while request side still busy");

  // walk commands only while no request can be taken
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.key_step || cmd.edge_step || cmd.pop_read) |-> !req.ready)
    else $error("key walk or pop running while request port is ready");

endmodule

[sim/multi_key_debounce_long_press_fifo_tb.sv]
// self-checking testbench for the debounced key scanner with long-press codes and code fifo
module multi_key_debounce_long_press_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mkd_pkg::*;

  localparam int NKEYS = NUM_KEYS_DEF;
  localparam int DEPTH = FIFO_DEPTH_DEF;
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_POP  = 1'b1;
  localparam int RANDOM_WORDS  = 1600;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 100;

  // one response word
  typedef struct packed {
    logic              code_added;
    logic [CODE_W-1:0] popped_code;
    logic              fifo_empty;
  } key_word_t;

  typedef enum logic [1:0] {ROW_SCAN, ROW_POP, ROW_CFG} row_kind_t;

  // directed row: a scan, a pop or a register write; arg is levels or write data
  typedef struct packed {
    row_kind_t          kind;
    logic [LEVEL_W-1:0] arg;
    cfg_idx_t           reg_idx;
    logic               typed;
    key_word_t          want;
  } stim_row_t;

  localparam key_word_t IDLE_EMPTY     = '{1'b0, 8'd0, 1'b1};
  localparam key_word_t ADDED_NONEMPTY = '{1'b1, 8'd0, 1'b0};
  localparam key_word_t NO_WANT        = '0;
  localparam int DIR_ROWS = 33;

  // reg_idx only matters on write rows
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // pop on an empty fifo, then the first sample of a pattern changes nothing
    '{ROW_POP,  32'hA5A5_5A5A, CFG_RELEASE_MODE,       1'b1, IDLE_EMPTY},
    '{ROW_SCAN, 32'h0000_0000, CFG_RELEASE_MODE,       1'b1, IDLE_EMPTY},
    '{ROW_SCAN, 32'h8000_0001, CFG_RELEASE_MODE,       1'b1, IDLE_EMPTY},
    // short thresholds: press edge, long code, ceiling, up key repeat
    '{ROW_CFG,  32'd2,         CFG_PRESS_LONG_THRE,    1'b0, NO_WANT},
    '{ROW_CFG,  32'd3,         CFG_HOLD_COUNT_MAX,     1'b0, NO_WANT},
    '{ROW_SCAN, 32'h8000_0001, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h8000_0001, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h8000_0001, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h8000_0001, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0001, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_POP,  32'hFFFF_FFFF, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_POP,  32'h0000_0000, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    // release mode with both offsets at the top, sums wrap
    '{ROW_CFG,  32'd1,         CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_CFG,  32'd2,         CFG_RELEASE_LONG_THRE,  1'b0, NO_WANT},
    '{ROW_CFG,  32'd3,         CFG_RELEASE_EXTRA_THRE, 1'b0, NO_WANT},
    '{ROW_CFG,  32'd255,       CFG_LONG_OFFSET,        1'b0, NO_WANT},
    '{ROW_CFG,  32'd255,       CFG_EXTRA_LONG_OFFSET,  1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0000, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0000, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    // no keys examined, then a key count above the key total
    '{ROW_CFG,  32'd0,         CFG_KEY_COUNT,          1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0002, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0002, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_CFG,  32'd40,        CFG_KEY_COUNT,          1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0000, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0000, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    // back to press mode: every key rises at once and fills the fifo
    '{ROW_CFG,  32'd0,         CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_CFG,  32'd32,        CFG_KEY_COUNT,          1'b0, NO_WANT},
    '{ROW_SCAN, 32'hFFFF_FFFF, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'hFFFF_FFFF, CFG_RELEASE_MODE,       1'b1, ADDED_NONEMPTY},
    '{ROW_SCAN, 32'hFFFF_FFFF, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_POP,  32'h5A5A_A5A5, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0000, CFG_RELEASE_MODE,       1'b0, NO_WANT},
    '{ROW_SCAN, 32'h0000_0000, CFG_RELEASE_MODE,       1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst;

  mkd_req_if req_bus ();
  mkd_rsp_if rsp_bus ();
  mkd_cfg_if cfg_bus ();

  multi_key_debounce_long_press_fifo dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  // scanner state as the block should hold it
  cfg_t               cfg_shadow;
  logic [LEVEL_W-1:0] last_sample;
  logic [LEVEL_W-1:0] debounced;
  logic [CNT_W-1:0]   hold_cnt [NKEYS];
  logic [CODE_W-1:0]  code_ring [DEPTH];
  int                 rd_idx;
  int                 wr_idx;

  key_word_t          pending_words [$];
  key_word_t          rsp_word;
  key_word_t          want_word;
  int                 mismatch_count = 0;
  int                 burst_left = 0;
  bit                 sender_steady = 1'b0;
  logic [LEVEL_W-1:0] held_keys = '0;

  // ring push, refused when only one slot is left
  function automatic bit ring_push(input int code);
    int nxt;
    nxt = (wr_idx == DEPTH - 1) ? 0 : wr_idx + 1;
    if (nxt == rd_idx) return 1'b0;
    code_ring[wr_idx] = code[CODE_W-1:0];
    wr_idx = nxt;
    return 1'b1;
  endfunction

  // response word that one request word should cause; updates the scanner state
  function automatic key_word_t next_key_word(input logic kind, input logic [LEVEL_W-1:0] lv);
    key_word_t          w;
    logic [LEVEL_W-1:0] prior;
    logic [LEVEL_W-1:0] now_st;
    logic [LEVEL_W-1:0] edges;
    logic               rel;
    int                 n;
    int                 kc;
    int                 cnt;
    w = '0;
    if (kind == REQ_POP) begin
      if (rd_idx != wr_idx) begin
        w.popped_code = code_ring[rd_idx];
        rd_idx = (rd_idx == DEPTH - 1) ? 0 : rd_idx + 1;
      end
    end else begin
      // a level moves only when two samples in a row agree
      prior  = debounced;
      now_st = prior | (lv & last_sample);
      now_st = now_st & (lv | last_sample);
      last_sample = lv;
      rel    = cfg_shadow.release_mode;
      edges  = (now_st ^ prior) & (rel ? prior : now_st);
      debounced = now_st;
      n = (cfg_shadow.key_count > NKEYS) ? NKEYS : int'(cfg_shadow.key_count);
      for (int i = 0; i < n; i++) begin
        kc  = i + 1;
        cnt = int'(hold_cnt[i]);
        // hold count, long code and auto repeat
        if (now_st[i]) begin
          if (cnt < cfg_shadow.hold_count_max) begin
            cnt++;
            hold_cnt[i] = cnt[CNT_W-1:0];
            if (cnt == cfg_shadow.press_long_thre && !rel) begin
              if (ring_push(kc + cfg_shadow.long_offset)) w.code_added = 1'b1;
            end
          end else if (kc == UP_KEY_CODE || kc == DOWN_KEY_CODE) begin
            hold_cnt[i] = cfg_shadow.press_long_thre;
            if (ring_push(kc)) w.code_added = 1'b1;
          end
        end else if (!rel) begin
          hold_cnt[i] = '0;
        end
        // edge code; a refused push ends the walk
        if (edges[i]) begin
          if (rel) begin
            cnt = int'(hold_cnt[i]);
            if (cnt >= cfg_shadow.release_long_thre) kc += cfg_shadow.long_offset;
            if (cnt >= cfg_shadow.release_extra_thre) kc += cfg_shadow.extra_long_offset;
            hold_cnt[i] = '0;
          end
          if (ring_push(kc)) w.code_added = 1'b1;
          else break;
        end
      end
    end
    w.fifo_empty = (rd_idx == wr_idx);
    return w;
  endfunction

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: ready follows a 16-bit pattern redrawn every stretch
  logic [15:0] stall_pat = 16'hFFFF;
  int          stall_left = 0;
  int          stall_pos = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom);
        default: stall_pat = 16'($urandom & $urandom & $urandom);
      endcase
      stall_pat[0] = 1'b1;
      stall_left = $urandom_range(16, 200);
    end
    stall_left--;
    stall_pos = (stall_pos + 1) % 16;
    rsp_bus.ready <= stall_pat[stall_pos];
  end

  // response check, sampled mid-cycle where every signal has settled
  always @(negedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      rsp_word = '{rsp_bus.code_added, rsp_bus.popped_code, rsp_bus.fifo_empty};
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected response word: added=%0b code=%0d empty=%0b",
                   rsp_word.code_added, rsp_word.popped_code, rsp_word.fifo_empty);
      end else begin
        want_word = pending_words.pop_front();
        if (rsp_word.code_added !== want_word.code_added ||
            rsp_word.popped_code !== want_word.popped_code ||
            rsp_word.fifo_empty !== want_word.fifo_empty) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"response word mismatch: expected added=%0b code=%0d empty=%0b,",
                      " got added=%0b code=%0d empty=%0b"},
                     want_word.code_added, want_word.popped_code, want_word.fifo_empty,
                     rsp_word.code_added, rsp_word.popped_code, rsp_word.fifo_empty);
        end
      end
    end
  end

  // register write; called at a rising edge, returns at one
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(negedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_RELEASE_MODE:       cfg_shadow.release_mode       = val[0];
      CFG_KEY_COUNT:          cfg_shadow.key_count          = val[KCNT_W-1:0];
      CFG_RELEASE_LONG_THRE:  cfg_shadow.release_long_thre  = val;
      CFG_RELEASE_EXTRA_THRE: cfg_shadow.release_extra_thre = val;
      CFG_PRESS_LONG_THRE:    cfg_shadow.press_long_thre    = val;
      CFG_HOLD_COUNT_MAX:     cfg_shadow.hold_count_max     = val;
      CFG_LONG_OFFSET:        cfg_shadow.long_offset        = val[CODE_W-1:0];
      default:                cfg_shadow.extra_long_offset  = val[CODE_W-1:0];
    endcase
    @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every expected word is back
  task automatic wait_idle;
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    burst_left = 0;
  endtask

  // send one request word in bursts with random gaps
  task automatic send_word(input logic kind, input logic [LEVEL_W-1:0] lv,
                           input logic typed, input key_word_t want);
    int        gap;
    key_word_t predicted;
    if (burst_left == 0) begin
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.key_levels <= lv;
    do @(negedge clk); while (!req_bus.ready);
    predicted = next_key_word(kind, lv);
    pending_words.push_back(typed ? want : predicted);
    @(posedge clk);
  endtask

  // run limit
  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  // main sequence
  initial begin
    int                    words_sent;
    int                    phase_len;
    int                    pop_pct;
    int                    style;
    int                    span;
    int                    key_bit;
    logic [CFG_DATA_W-1:0] vals [8];
    logic [LEVEL_W-1:0]    sample;

    // reset values of the scanner state
    cfg_shadow = '{1'b0, 6'd32, 16'd100, 16'd300, 16'd100, 16'd150, 8'd64, 8'd128};
    last_sample = '0;
    debounced   = '0;
    foreach (hold_cnt[k]) hold_cnt[k] = '0;
    foreach (code_ring[k]) code_ring[k] = '0;
    rd_idx = 0;
    wr_idx = 0;

    rst                <= 1'b1;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= REQ_SCAN;
    req_bus.key_levels <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_RELEASE_MODE;
    cfg_bus.data       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      case (DIR_TABLE[r].kind)
        ROW_CFG: begin
          wait_idle;
          write_reg(DIR_TABLE[r].reg_idx, DIR_TABLE[r].arg[CFG_DATA_W-1:0]);
        end
        ROW_POP: send_word(REQ_POP, DIR_TABLE[r].arg, DIR_TABLE[r].typed, DIR_TABLE[r].want);
        default: send_word(REQ_SCAN, DIR_TABLE[r].arg, DIR_TABLE[r].typed, DIR_TABLE[r].want);
      endcase
    end

    // random phases, each under a fresh register setting
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      wait_idle;
      style = $urandom_range(0, 9);
      if (style < 2) begin
        // extremes
        vals[0] = CFG_DATA_W'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       vals[1] = CFG_DATA_W'(0);
          1:       vals[1] = CFG_DATA_W'(1);
          2:       vals[1] = CFG_DATA_W'(32);
          default: vals[1] = CFG_DATA_W'(63);
        endcase
        for (int k = 2; k < 6; k++) vals[k] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        for (int k = 6; k < 8; k++) vals[k] = $urandom_range(0, 1) ? 16'h00FF : 16'h0000;
      end else if (style == 2) begin
        // anything the registers hold
        vals[0] = CFG_DATA_W'($urandom_range(0, 1));
        vals[1] = CFG_DATA_W'($urandom_range(0, 63));
        for (int k = 2; k < 6; k++) vals[k] = CFG_DATA_W'($urandom);
        for (int k = 6; k < 8; k++) vals[k] = CFG_DATA_W'($urandom_range(0, 255));
      end else begin
        // short thresholds so holds reach long codes and repeats
        vals[0] = CFG_DATA_W'($urandom_range(0, 1));
        vals[1] = $urandom_range(0, 1) ? CFG_DATA_W'(32) : CFG_DATA_W'($urandom_range(0, 63));
        vals[2] = CFG_DATA_W'($urandom_range(0, 8));
        vals[3] = CFG_DATA_W'($urandom_range(0, 16));
        vals[4] = CFG_DATA_W'($urandom_range(0, 8));
        vals[5] = CFG_DATA_W'($urandom_range(0, 12));
        vals[6] = CFG_DATA_W'($urandom_range(0, 255));
        vals[7] = CFG_DATA_W'($urandom_range(0, 255));
      end
      for (int k = 0; k < 8; k++) write_reg(cfg_idx_t'(k), vals[k]);

      phase_len = $urandom_range(40, 150);
      case ($urandom_range(0, 3))
        0:       pop_pct = 5;
        1:       pop_pct = 25;
        2:       pop_pct = 50;
        default: pop_pct = 75;
      endcase
      sender_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1) == 0) held_keys = '0;
      span = (cfg_shadow.key_count == 0 || cfg_shadow.key_count > NKEYS) ?
             NKEYS : int'(cfg_shadow.key_count);

      repeat (phase_len) begin
        if ($urandom_range(0, 199) == 0) wait_idle;
        if ($urandom_range(1, 100) <= pop_pct) begin
          send_word(REQ_POP, $urandom, 1'b0, NO_WANT);
        end else begin
          // keys held for a while, with glitches and the odd noise word
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 9))
              0:       held_keys = $urandom;
              1:       held_keys = '0;
              2:       held_keys = '1;
              default: begin
                key_bit = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1) :
                          $urandom_range(0, span - 1);
                held_keys[key_bit] = ~held_keys[key_bit];
              end
            endcase
          end
          sample = held_keys;
          if ($urandom_range(0, 5) == 0) begin
            key_bit = $urandom_range(0, LEVEL_W - 1);
            sample[key_bit] = ~sample[key_bit];
          end else if ($urandom_range(0, 29) == 0) begin
            sample = $urandom;
          end
          send_word(REQ_SCAN, sample, 1'b0, NO_WANT);
        end
        words_sent++;
      end
    end

    // drain and settle
    wait_idle;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_req_if.sv
hw/rtl/mkd_rsp_if.sv
hw/rtl/mkd_cfg_if.sv
hw/rtl/mkd_ram.sv
hw/rtl/mkd_ctrl.sv
hw/rtl/mkd_dp.sv
hw/rtl/multi_key_debounce_long_press_fifo.sv
sim/multi_key_debounce_long_press_fifo_tb.sv
